// ===== rtl/sorted_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// general property under clock, disabled while in reset
`define SPQ_CHECK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// combinational condition that must hold at every edge out of reset
`define SPQ_ALWAYS(label, clk, rst_n, cond) \
  `SPQ_CHECK(label, clk, rst_n, (cond))

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic [STATUS_W-1:0]       status;
    logic [FILL_W-1:0]         fill_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                write_insert;
    logic                write_pop;
    logic                load_result;
    logic [STATUS_W-1:0] result_code;
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// two-state sequencer: capture a beat, then apply it and load the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // the output register is always free in apply: ready required it on accept
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_APPLY) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd              = '0;
    cmd.capture      = accept;
    cmd.load_result  = (state_r == ST_APPLY);
    cmd.write_insert = (state_r == ST_APPLY) && !stat.is_pop && !stat.full;
    cmd.write_pop    = (state_r == ST_APPLY) && stat.is_pop && !stat.empty;
    priority if (stat.is_pop && stat.empty) begin
      cmd.result_code = STATUS_EMPTY;
    end else if (!stat.is_pop && stat.full) begin
      cmd.result_code = STATUS_FULL;
    end else begin
      cmd.result_code = STATUS_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// row of sorted cells with parallel compare and one-step shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spq_pkg::in_item_t   in_data,
  input  spq_pkg::spq_cmd_t   cmd,
  output spq_pkg::spq_stat_t  stat,
  output spq_pkg::out_item_t  out_data
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0][VALUE_W-1:0] cell_r;
  logic [CAPACITY-1:0][VALUE_W-1:0] cell_nxt;
  logic [CAPACITY-1:0]              ge_r;
  logic [CAPACITY-1:0]              stay;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic                             kind_r;
  logic signed [VALUE_W-1:0]        value_r;
  out_item_t                        out_data_r;

  assign stat.is_pop = (kind_r == KIND_POP);
  assign stat.full   = (count_r == CNT_W'(CAPACITY));
  assign stat.empty  = (count_r == '0);

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [VALUE_W-1:0] ins_src;
    logic [VALUE_W-1:0] pop_src;

    // cell stays put when it holds a value smaller than the new one
    assign stay[gi] = (CNT_W'(gi) < count_r) && !ge_r[gi];

    if (gi == 0) begin : g_head
      assign ins_src = value_r;
    end else begin : g_body
      assign ins_src = stay[gi-1] ? value_r : cell_r[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_tail
      assign pop_src = cell_r[gi];
    end else begin : g_inner
      assign pop_src = cell_r[gi+1];
    end

    assign cell_nxt[gi] = (cmd.write_insert && !stay[gi]) ? ins_src :
                          cmd.write_pop                   ? pop_src :
                                                            cell_r[gi];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.write_insert) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (cmd.write_pop) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (cmd.capture) begin
      kind_r  <= in_data.kind;
      value_r <= in_data.value;
      for (int i = 0; i < CAPACITY; i++) begin
        ge_r[i] <= ($signed(cell_r[i]) >= in_data.value);
      end
    end
    if (cmd.load_result) begin
      out_data_r.popped_value <= cmd.write_pop ? $signed(cell_r[0]) : '0;
      out_data_r.status       <= cmd.result_code;
      out_data_r.fill_level   <= FILL_W'(count_nxt);
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded ascending priority queue of signed 32-bit values
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  in_       in    in_valid / in_ready    spq_pkg::in_item_t  (kind, value)
//  out_      out   out_valid / out_ready  spq_pkg::out_item_t (popped_value,
//                                                              status, fill_level)
//
//  every beat is captured and compared against all cells in parallel, then
//  the cell row is shifted and the result register loaded.
//  one beat in flight at a time; the next is taken as the result leaves.
//  out_ready low holds the result and keeps in_ready low after it is loaded.
//  synchronous active-low reset empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  logic empty_pop_ok;
  logic full_zero_ok;

  assign empty_pop_ok = !out_valid || out_data.status != STATUS_EMPTY ||
                        (out_data.fill_level == '0 && out_data.popped_value == '0);
  assign full_zero_ok = !out_valid || out_data.status != STATUS_FULL ||
                        out_data.popped_value == '0;

  // a stalled result holds
  `SPQ_CHECK(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable(out_data)))

  // an accepted beat shows its result once the apply state has loaded it
  `SPQ_CHECK(a_result_due, clk, rst_n, (in_valid && in_ready |-> ##2 out_valid))

  // one beat at a time
  `SPQ_CHECK(a_one_in_flight, clk, rst_n, (in_valid && in_ready |=> !in_ready))

  // empty pop leaves nothing and returns zero
  `SPQ_ALWAYS(a_empty_pop, clk, rst_n, empty_pop_ok)

  // a rejected insert returns zero
  `SPQ_ALWAYS(a_full_zero, clk, rst_n, full_zero_ok)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted priority queue testbench
// drives insert and pop beats with random gaps and receiver stalls, keeps a
// sorted shadow copy of the queue to predict each result beat, and compares
// every result field against the oldest pending prediction
// ----------------------------------------------------------------------------

module testbench;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_BEATS = 1880;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // sorted copy of the queue contents, smallest first
  logic signed [VALUE_W-1:0] shadow_entries[$];
  out_item_t                 pending_results[$];

  int          mismatch_count = 0;
  int          beats_sent     = 0;
  int          cycle_count    = 0;
  int unsigned hold_left      = 0;
  int unsigned stall_left     = 0;
  bit          gaps_on        = 1'b1;

  sorted_priority_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 2);
    else if (r < 94) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] r;
    case ($urandom_range(9))
      0: r = 32'h7fff_ffff;
      1: r = 32'h8000_0000;
      // narrow range so equal keys show up often
      2, 3, 4: r = 32'($urandom_range(16)) - 32'd8;
      default: r = $urandom;
    endcase
    return r;
  endfunction

  function automatic out_item_t compute_result(in_item_t beat);
    out_item_t res;
    int        pos;
    res = '0;
    if (beat.kind == KIND_INSERT) begin
      if (shadow_entries.size() >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pos = shadow_entries.size();
        for (int i = 0; i < shadow_entries.size(); i++) begin
          if (shadow_entries[i] >= beat.value) begin
            pos = i;
            break;
          end
        end
        shadow_entries.insert(pos, beat.value);
        res.status = STATUS_DONE;
      end
    end else begin
      if (shadow_entries.size() == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.popped_value = shadow_entries.pop_front();
        res.status = STATUS_DONE;
      end
    end
    res.fill_level = FILL_W'(shadow_entries.size());
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    bit        bad;
    if (pending_results.size() == 0) begin
      log_mismatch($sformatf("unexpected beat popped_value %0d status %0d fill %0d",
                             got.popped_value, got.status, got.fill_level));
      return;
    end
    want = pending_results.pop_front();
    bad = 1'b0;
    if (got.popped_value !== want.popped_value) bad = 1'b1;
    if (got.status !== want.status) bad = 1'b1;
    if (got.fill_level !== want.fill_level) bad = 1'b1;
    if (bad)
      log_mismatch($sformatf(
          "popped_value exp %0d got %0d, status exp %0d got %0d, fill exp %0d got %0d",
          want.popped_value, got.popped_value, want.status, got.status,
          want.fill_level, got.fill_level));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) check_result(out_data);
  end

  // receiver: a requested hold first, then random stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (gaps_on && $urandom_range(99) < 30) stall_left <= gap_len();
    end
  end

  // called right after a rising edge; returns right after the accepting edge
  // or after the idle gap that follows it
  task automatic send_op(input logic kind, input logic signed [VALUE_W-1:0] value);
    in_item_t    beat;
    int unsigned gap;
    beat.kind  = kind;
    beat.value = value;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.push_back(compute_result(beat));
    beats_sent++;
    gap = (gaps_on && $urandom_range(99) < 35) ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_pop_on_empty();
    send_op(KIND_POP, 32'sd0);
  endtask

  // head, tail, middle and equal-key inserts up to a full queue, then rejected inserts and pops
  task automatic test_ordering_and_full();
    logic signed [VALUE_W-1:0] vals[16];
    vals = '{32'sd0, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd1,
             32'sd0, 32'sd1, 32'sh7fff_ffff, 32'sh8000_0000,
             32'sd5, -32'sd5, 32'sd100, -32'sd100,
             32'sd2, -32'sd2, 32'sd3, 32'sh4000_0000};
    foreach (vals[i]) send_op(KIND_INSERT, vals[i]);
    send_op(KIND_INSERT, 32'sd0);
    send_op(KIND_INSERT, 32'sh8000_0000);
    repeat (3) send_op(KIND_POP, 32'sh5555_5555);
  endtask

  // result held back while the sender keeps offering beats
  task automatic test_receiver_hold();
    hold_left = HOLD_CYCLES;
    repeat (12) send_op(logic'($urandom_range(1)), rand_value());
  endtask

  // sender goes quiet until all results are back, then empties the queue
  task automatic test_pause_and_drain();
    repeat (6) send_op(logic'($urandom_range(1)), rand_value());
    wait_results_drained();
    while (shadow_entries.size() != 0) send_op(KIND_POP, rand_value());
    send_op(KIND_POP, rand_value());
  endtask

  // phases lean toward filling, draining or neither so both bounds get hit
  task automatic test_random_mix();
    int          stop_at;
    int          phase_len;
    int unsigned insert_pct;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(2))
        0: insert_pct = 80;
        1: insert_pct = 20;
        default: insert_pct = 50;
      endcase
      gaps_on = ($urandom_range(3) != 0);
      repeat (phase_len) begin
        if ($urandom_range(99) < insert_pct) send_op(KIND_INSERT, rand_value());
        else send_op(KIND_POP, rand_value());
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pop_on_empty();
    test_ordering_and_full();
    test_receiver_hold();
    test_pause_and_drain();
    test_random_mix();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
